### rtl/pnad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnad_pkg
// Shared constants and helper functions for the plane normal angle deviation
// pipeline.
// ----------------------------------------------------------------------------
package pnad_pkg;

   localparam int MANT_BITS      = 24;
   localparam int PAIR_BITS      = 30;
   localparam int CORDIC_STEPS   = 28;
   localparam int DEV_WIDTH      = 17;
   localparam int RSP_DATA_WIDTH = 24;
   localparam int Q_WIDTH        = 2 * PAIR_BITS + 2;
   localparam int ROOT_WIDTH     = PAIR_BITS + 1;
   localparam int SQRT_STEPS     = Q_WIDTH / 2;
   localparam int LEN_WIDTH      = 8;

   localparam logic [DEV_WIDTH-1:0] HALF_PI_Q16 = 17'd102944;

   // atan(2^-i) in Q30, truncated.
   localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008
   };

   // Number of significant bits of an unsigned word.
   function automatic logic [LEN_WIDTH-1:0] bitlen128(input logic [127:0] v);
      logic [LEN_WIDTH-1:0] n;
      n = '0;
      for (int i = 0; i < 128; i++) begin
         if (v[i]) begin
            n = LEN_WIDTH'(i + 1);
         end
      end
      return n;
   endfunction

   // Scales a magnitude so that a word of length len lands on MANT_BITS bits,
   // then applies the sign.
   function automatic logic signed [MANT_BITS:0] norm_mant(input logic [127:0] m,
                                                         input logic [LEN_WIDTH-1:0] len,
                                                         input logic neg);
      logic [127:0]         r;
      logic [MANT_BITS:0]   u;
      if (len > LEN_WIDTH'(MANT_BITS)) begin
         r = m >> (len - LEN_WIDTH'(MANT_BITS));
      end else begin
         r = m << (LEN_WIDTH'(MANT_BITS) - len);
      end
      u = {1'b0, r[MANT_BITS-1:0]};
      return neg ? -u : u;
   endfunction

endpackage

### rtl/pnad_cross.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnad_cross
// Difference vectors, cross product partial products and the plane normal.
// Three register stages.
// ----------------------------------------------------------------------------
module pnad_cross #(
   parameter int CW = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [CW-1:0]        a_x,
   input  logic [CW-1:0]        a_y,
   input  logic [CW-1:0]        a_z,
   input  logic [CW-1:0]        n1_x,
   input  logic [CW-1:0]        n1_y,
   input  logic [CW-1:0]        n1_z,
   input  logic [CW-1:0]        n2_x,
   input  logic [CW-1:0]        n2_y,
   input  logic [CW-1:0]        n2_z,
   input  logic [CW-1:0]        b_x,
   input  logic [CW-1:0]        b_y,
   input  logic [CW-1:0]        b_z,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic signed [2*CW+2:0] c_out [3],
   output logic signed [CW:0]     t_out [3]
);

   localparam int DW = CW + 1;
   localparam int PW = 2 * CW + 2;
   localparam int XW = 2 * CW + 3;

   logic              v1_ff, v2_ff, v3_ff;
   logic              en1, en2, en3;
   logic signed [DW-1:0] d1_ff [3];
   logic signed [DW-1:0] d2_ff [3];
   logic signed [DW-1:0] t1_ff [3];
   logic signed [DW-1:0] t2_ff [3];
   logic signed [DW-1:0] t3_ff [3];
   logic signed [PW-1:0] p_ff  [6];
   logic signed [XW-1:0] c_ff  [3];
   logic signed [DW-1:0] d1_in [3];
   logic signed [DW-1:0] d2_in [3];
   logic signed [DW-1:0] t_in  [3];

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   assign d1_in[0] = {n1_x[CW-1], n1_x} - {a_x[CW-1], a_x};
   assign d1_in[1] = {n1_y[CW-1], n1_y} - {a_y[CW-1], a_y};
   assign d1_in[2] = {n1_z[CW-1], n1_z} - {a_z[CW-1], a_z};
   assign d2_in[0] = {n2_x[CW-1], n2_x} - {a_x[CW-1], a_x};
   assign d2_in[1] = {n2_y[CW-1], n2_y} - {a_y[CW-1], a_y};
   assign d2_in[2] = {n2_z[CW-1], n2_z} - {a_z[CW-1], a_z};
   assign t_in[0]  = {b_x[CW-1], b_x} - {a_x[CW-1], a_x};
   assign t_in[1]  = {b_y[CW-1], b_y} - {a_y[CW-1], a_y};
   assign t_in[2]  = {b_z[CW-1], b_z} - {a_z[CW-1], a_z};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
         t1_ff <= t_in;
      end
      if (en2) begin
         p_ff[0] <= d1_ff[1] * d2_ff[2];
         p_ff[1] <= d1_ff[2] * d2_ff[1];
         p_ff[2] <= d1_ff[2] * d2_ff[0];
         p_ff[3] <= d1_ff[0] * d2_ff[2];
         p_ff[4] <= d1_ff[0] * d2_ff[1];
         p_ff[5] <= d1_ff[1] * d2_ff[0];
         t2_ff   <= t1_ff;
      end
      if (en3) begin
         c_ff[0] <= XW'(p_ff[0]) - XW'(p_ff[1]);
         c_ff[1] <= XW'(p_ff[2]) - XW'(p_ff[3]);
         c_ff[2] <= XW'(p_ff[4]) - XW'(p_ff[5]);
         t3_ff   <= t2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign c_out     = c_ff;
   assign t_out     = t3_ff;

endmodule

### rtl/pnad_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnad_norm
// Block-floating normalization of the normal and the target vector to
// MANT_BITS-bit mantissas. Two register stages.
// ----------------------------------------------------------------------------
module pnad_norm #(
   parameter int CW = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [2*CW+2:0] c_in [3],
   input  logic signed [CW:0]     t_in [3],
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic signed [pnad_pkg::MANT_BITS:0] n_out [3],
   output logic signed [pnad_pkg::MANT_BITS:0] v_out [3],
   output logic                  degen_out
);
   import pnad_pkg::*;

   localparam int XW = 2 * CW + 3;
   localparam int DW = CW + 1;

   logic                  v1_ff, v2_ff, en1, en2;
   logic [XW-1:0]         cm_in [3];
   logic [DW-1:0]         tm_in [3];
   logic [XW-1:0]         cm_ff [3];
   logic [DW-1:0]         tm_ff [3];
   logic [2:0]            cneg_ff, tneg_ff;
   logic [LEN_WIDTH-1:0]  clen_ff, tlen_ff;
   logic signed [MANT_BITS:0] n_ff [3];
   logic signed [MANT_BITS:0] v_ff [3];
   logic                  degen_ff;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cm_in[i] = c_in[i][XW-1] ? XW'(-c_in[i]) : XW'(c_in[i]);
         tm_in[i] = t_in[i][DW-1] ? DW'(-t_in[i]) : DW'(t_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         cm_ff   <= cm_in;
         tm_ff   <= tm_in;
         cneg_ff <= {c_in[2][XW-1], c_in[1][XW-1], c_in[0][XW-1]};
         tneg_ff <= {t_in[2][DW-1], t_in[1][DW-1], t_in[0][DW-1]};
         // The length of the largest magnitude equals the length of their OR.
         clen_ff <= bitlen128(128'(cm_in[0] | cm_in[1] | cm_in[2]));
         tlen_ff <= bitlen128(128'(tm_in[0] | tm_in[1] | tm_in[2]));
      end
      if (en2) begin
         for (int i = 0; i < 3; i++) begin
            n_ff[i] <= norm_mant(128'(cm_ff[i]), clen_ff, cneg_ff[i]);
            v_ff[i] <= norm_mant(128'(tm_ff[i]), tlen_ff, tneg_ff[i]);
         end
         degen_ff <= (clen_ff == '0) || (tlen_ff == '0);
      end
   end

   assign out_valid = v2_ff;
   assign n_out     = n_ff;
   assign v_out     = v_ff;
   assign degen_out = degen_ff;

endmodule

### rtl/pnad_dot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnad_dot
// Dot and cross product of the normalized vectors, common scaling of the
// pair and the sum of squares of the cross product. Five register stages.
// ----------------------------------------------------------------------------
module pnad_dot (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [pnad_pkg::MANT_BITS:0] n_in [3],
   input  logic signed [pnad_pkg::MANT_BITS:0] v_in [3],
   input  logic                  degen_in,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [pnad_pkg::PAIR_BITS-1:0] y_out,
   output logic [pnad_pkg::Q_WIDTH-1:0]   q_out,
   output logic                  degen_out
);
   import pnad_pkg::*;

   localparam int PW  = 2 * (MANT_BITS + 1);
   localparam int SW  = PW + 2;
   localparam int SQW = 2 * PAIR_BITS;

   logic [4:0]             v_ff;
   logic [4:0]             en;
   logic [4:0]             dg_ff;
   logic signed [PW-1:0]   p_ff [9];
   logic signed [SW-1:0]   s_in [4];
   logic [SW-1:0]          m2_ff [4];
   logic [SW-1:0]          m3_ff [4];
   logic [LEN_WIDTH-1:0]   len_in;
   logic [LEN_WIDTH-1:0]   sh_ff;
   logic [PAIR_BITS-1:0]   c_in [3];
   logic [SQW-1:0]         sq_ff [3];
   logic [PAIR_BITS-1:0]   y4_ff, y5_ff;
   logic [Q_WIDTH-1:0]     q_ff;

   assign en[4]    = !v_ff[4] || out_ready;
   assign en[3]    = !v_ff[3] || en[4];
   assign en[2]    = !v_ff[2] || en[3];
   assign en[1]    = !v_ff[1] || en[2];
   assign en[0]    = !v_ff[0] || en[1];
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         for (int i = 1; i < 5; i++) begin
            if (en[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // Index 0 is the dot product, 1 to 3 the cross product components.
   assign s_in[0] = SW'(p_ff[0]) + SW'(p_ff[1]) + SW'(p_ff[2]);
   assign s_in[1] = SW'(p_ff[3]) - SW'(p_ff[4]);
   assign s_in[2] = SW'(p_ff[5]) - SW'(p_ff[6]);
   assign s_in[3] = SW'(p_ff[7]) - SW'(p_ff[8]);

   assign len_in = bitlen128(128'(m2_ff[0] | m2_ff[1] | m2_ff[2] | m2_ff[3]));

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c_in[i] = PAIR_BITS'(m3_ff[i+1] >> sh_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p_ff[0]  <= n_in[0] * v_in[0];
         p_ff[1]  <= n_in[1] * v_in[1];
         p_ff[2]  <= n_in[2] * v_in[2];
         p_ff[3]  <= n_in[1] * v_in[2];
         p_ff[4]  <= n_in[2] * v_in[1];
         p_ff[5]  <= n_in[2] * v_in[0];
         p_ff[6]  <= n_in[0] * v_in[2];
         p_ff[7]  <= n_in[0] * v_in[1];
         p_ff[8]  <= n_in[1] * v_in[0];
         dg_ff[0] <= degen_in;
      end
      if (en[1]) begin
         for (int i = 0; i < 4; i++) begin
            m2_ff[i] <= s_in[i][SW-1] ? SW'(-s_in[i]) : SW'(s_in[i]);
         end
         dg_ff[1] <= dg_ff[0];
      end
      if (en[2]) begin
         m3_ff    <= m2_ff;
         sh_ff    <= (len_in > LEN_WIDTH'(PAIR_BITS)) ? len_in - LEN_WIDTH'(PAIR_BITS) : '0;
         dg_ff[2] <= dg_ff[1];
      end
      if (en[3]) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= SQW'(c_in[i]) * SQW'(c_in[i]);
         end
         y4_ff    <= PAIR_BITS'(m3_ff[0] >> sh_ff);
         dg_ff[3] <= dg_ff[2];
      end
      if (en[4]) begin
         q_ff     <= Q_WIDTH'(sq_ff[0]) + Q_WIDTH'(sq_ff[1]) + Q_WIDTH'(sq_ff[2]);
         y5_ff    <= y4_ff;
         dg_ff[4] <= dg_ff[3];
      end
   end

   assign out_valid = v_ff[4];
   assign y_out     = y5_ff;
   assign q_out     = q_ff;
   assign degen_out = dg_ff[4];

endmodule

### rtl/pnad_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnad_sqrt
// Pipelined restoring integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module pnad_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [pnad_pkg::Q_WIDTH-1:0]   q_in,
   input  logic [pnad_pkg::PAIR_BITS-1:0] y_in,
   input  logic                  degen_in,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [pnad_pkg::ROOT_WIDTH-1:0] x_out,
   output logic [pnad_pkg::PAIR_BITS-1:0]  y_out,
   output logic                  degen_out
);
   import pnad_pkg::*;

   localparam int RW = Q_WIDTH + 1;

   logic [SQRT_STEPS-1:0]  v_ff;
   logic [SQRT_STEPS:0]    en;
   logic [SQRT_STEPS-1:0]  dg_ff;
   logic [Q_WIDTH-1:0]     q_ff   [SQRT_STEPS];
   logic [RW-1:0]          res_ff [SQRT_STEPS];
   logic [PAIR_BITS-1:0]   y_ff   [SQRT_STEPS];

   assign en[SQRT_STEPS] = out_ready;
   assign in_ready       = en[0];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [RW-1:0] BIT = RW'(1) << (Q_WIDTH - 2 - 2 * k);

      logic [Q_WIDTH-1:0]   q_src;
      logic [RW-1:0]        res_src;
      logic [PAIR_BITS-1:0] y_src;
      logic                 dg_src, v_src;
      logic [RW-1:0]        trial;

      if (k == 0) begin : g_first
         assign q_src   = q_in;
         assign res_src = '0;
         assign y_src   = y_in;
         assign dg_src  = degen_in;
         assign v_src   = in_valid;
      end else begin : g_next
         assign q_src   = q_ff[k-1];
         assign res_src = res_ff[k-1];
         assign y_src   = y_ff[k-1];
         assign dg_src  = dg_ff[k-1];
         assign v_src   = v_ff[k-1];
      end

      assign en[k] = !v_ff[k] || en[k+1];
      assign trial = res_src + BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            if (RW'(q_src) >= trial) begin
               q_ff[k]   <= q_src - Q_WIDTH'(trial);
               res_ff[k] <= (res_src >> 1) + BIT;
            end else begin
               q_ff[k]   <= q_src;
               res_ff[k] <= res_src >> 1;
            end
            y_ff[k]  <= y_src;
            dg_ff[k] <= dg_src;
         end
      end
   end

   assign out_valid = v_ff[SQRT_STEPS-1];
   assign x_out     = ROOT_WIDTH'(res_ff[SQRT_STEPS-1]);
   assign y_out     = y_ff[SQRT_STEPS-1];
   assign degen_out = dg_ff[SQRT_STEPS-1];

endmodule

### rtl/pnad_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnad_cordic
// Pipelined vectoring CORDIC, one rotation per stage, followed by the
// rounding and clamping output register.
// ----------------------------------------------------------------------------
module pnad_cordic (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [pnad_pkg::ROOT_WIDTH-1:0] x_in,
   input  logic [pnad_pkg::PAIR_BITS-1:0]  y_in,
   input  logic                  degen_in,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [pnad_pkg::DEV_WIDTH-1:0] dev_out,
   output logic                  degen_out
);
   import pnad_pkg::*;

   localparam int XW = ROOT_WIDTH + 5;
   localparam int ZW = 33;

   logic [CORDIC_STEPS-1:0] v_ff;
   logic [CORDIC_STEPS:0]   en;
   logic [CORDIC_STEPS-1:0] dg_ff;
   logic signed [XW-1:0]    x_ff [CORDIC_STEPS];
   logic signed [XW-1:0]    y_ff [CORDIC_STEPS];
   logic signed [ZW-1:0]    z_ff [CORDIC_STEPS];
   logic                    vo_ff, dgo_ff;
   logic [DEV_WIDTH-1:0]    dev_ff;
   logic signed [ZW-1:0]    z_fin, z_rnd;
   logic [ZW-15:0]          dev_wide;
   logic [DEV_WIDTH-1:0]    dev_in;

   assign in_ready = en[0];

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      logic signed [XW-1:0] x_src, y_src, dx, dy;
      logic [XW-1:0]        xm, ym;
      logic signed [ZW-1:0] z_src;
      logic                 dg_src, v_src;

      if (k == 0) begin : g_first
         assign x_src  = XW'(x_in);
         assign y_src  = XW'(y_in);
         assign z_src  = '0;
         assign dg_src = degen_in;
         assign v_src  = in_valid;
      end else begin : g_next
         assign x_src  = x_ff[k-1];
         assign y_src  = y_ff[k-1];
         assign z_src  = z_ff[k-1];
         assign dg_src = dg_ff[k-1];
         assign v_src  = v_ff[k-1];
      end

      // Shifts truncate toward zero, so they work on the magnitude.
      assign ym = y_src[XW-1] ? XW'(-y_src) : XW'(y_src);
      assign xm = x_src[XW-1] ? XW'(-x_src) : XW'(x_src);
      assign dx = y_src[XW-1] ? -$signed(ym >> k) : $signed(ym >> k);
      assign dy = x_src[XW-1] ? -$signed(xm >> k) : $signed(xm >> k);

      assign en[k] = !v_ff[k] || en[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            if (!y_src[XW-1]) begin
               x_ff[k] <= x_src + dx;
               y_ff[k] <= y_src - dy;
               z_ff[k] <= z_src + ZW'(ATAN_Q30[k]);
            end else begin
               x_ff[k] <= x_src - dx;
               y_ff[k] <= y_src + dy;
               z_ff[k] <= z_src - ZW'(ATAN_Q30[k]);
            end
            dg_ff[k] <= dg_src;
         end
      end
   end

   assign en[CORDIC_STEPS] = !vo_ff || out_ready;

   // Round the Q30 angle half up to Q16 and clamp to pi/2.
   assign z_fin    = z_ff[CORDIC_STEPS-1];
   assign z_rnd    = z_fin + ZW'(8192);
   assign dev_wide = (z_fin > 0) ? z_rnd[ZW-1:14] : '0;

   always_comb begin
      if (dg_ff[CORDIC_STEPS-1]) begin
         dev_in = HALF_PI_Q16;
      end else if (dev_wide > (ZW-14)'(HALF_PI_Q16)) begin
         dev_in = HALF_PI_Q16;
      end else begin
         dev_in = DEV_WIDTH'(dev_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en[CORDIC_STEPS]) begin
         vo_ff <= v_ff[CORDIC_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[CORDIC_STEPS]) begin
         dev_ff <= dev_in;
         dgo_ff <= dg_ff[CORDIC_STEPS-1];
      end
   end

   assign out_valid = vo_ff;
   assign dev_out   = dev_ff;
   assign degen_out = dgo_ff;

endmodule

### rtl/plane_normal_angle_deviation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_normal_angle_deviation_unit
// Deviation of a target vector from the plane through three atoms, as
// |pi/2 - angle(normal, target)| in Q1.16 radians, with a degenerate flag.
// ----------------------------------------------------------------------------
// Register stages from input accept to result valid: 3 cross product,
// 2 normalize, 5 dot/scale, 31 square root, 29 CORDIC and output stages.
// Throughput: one item per cycle while rsp_tready is high; every stage is a
// register with a valid bit, and an item moves on whenever the next stage has room.
// Reset clears all valid bits; data registers are not reset.
module plane_normal_angle_deviation_unit #(
   parameter int COORD_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // a_x, a_y, a_z, n1_x, n1_y, n1_z, n2_x, n2_y, n2_z, b_x, b_y, b_z from the
   // lowest bit up, COORD_WIDTH bits each, zero padding to a whole byte.
   input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // deviation [16:0], zero padding above.
   output logic [pnad_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // degenerate
   output logic rsp_tuser
);
   import pnad_pkg::*;

   localparam int CW = COORD_WIDTH;

   logic [CW-1:0]          f [12];
   logic                   c_valid, c_ready;
   logic signed [2*CW+2:0] c_vec [3];
   logic signed [CW:0]     t_vec [3];
   logic                   n_valid, n_ready, n_degen;
   logic signed [MANT_BITS:0] n_vec [3];
   logic signed [MANT_BITS:0] v_vec [3];
   logic                   d_valid, d_ready, d_degen;
   logic [PAIR_BITS-1:0]   d_y;
   logic [Q_WIDTH-1:0]     d_q;
   logic                   s_valid, s_ready, s_degen;
   logic [ROOT_WIDTH-1:0]  s_x;
   logic [PAIR_BITS-1:0]   s_y;
   logic [DEV_WIDTH-1:0]   dev;

   for (genvar i = 0; i < 12; i++) begin : g_field
      assign f[i] = req_tdata[i*CW +: CW];
   end

   pnad_cross #(.CW(CW)) u_cross (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .a_x      (f[0]),
      .a_y      (f[1]),
      .a_z      (f[2]),
      .n1_x     (f[3]),
      .n1_y     (f[4]),
      .n1_z     (f[5]),
      .n2_x     (f[6]),
      .n2_y     (f[7]),
      .n2_z     (f[8]),
      .b_x      (f[9]),
      .b_y      (f[10]),
      .b_z      (f[11]),
      .out_valid(c_valid),
      .out_ready(c_ready),
      .c_out    (c_vec),
      .t_out    (t_vec)
   );

   pnad_norm #(.CW(CW)) u_norm (
      .clock    (clock),
      .reset    (reset),
      .in_valid (c_valid),
      .in_ready (c_ready),
      .c_in     (c_vec),
      .t_in     (t_vec),
      .out_valid(n_valid),
      .out_ready(n_ready),
      .n_out    (n_vec),
      .v_out    (v_vec),
      .degen_out(n_degen)
   );

   pnad_dot u_dot (
      .clock    (clock),
      .reset    (reset),
      .in_valid (n_valid),
      .in_ready (n_ready),
      .n_in     (n_vec),
      .v_in     (v_vec),
      .degen_in (n_degen),
      .out_valid(d_valid),
      .out_ready(d_ready),
      .y_out    (d_y),
      .q_out    (d_q),
      .degen_out(d_degen)
   );

   pnad_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_valid (d_valid),
      .in_ready (d_ready),
      .q_in     (d_q),
      .y_in     (d_y),
      .degen_in (d_degen),
      .out_valid(s_valid),
      .out_ready(s_ready),
      .x_out    (s_x),
      .y_out    (s_y),
      .degen_out(s_degen)
   );

   pnad_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s_valid),
      .in_ready (s_ready),
      .x_in     (s_x),
      .y_in     (s_y),
      .degen_in (s_degen),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .dev_out  (dev),
      .degen_out(rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_WIDTH'(dev);

   // A degenerate item always reports a right angle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> dev == HALF_PI_Q16)
      else $error("degenerate item without pi/2 deviation");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> dev <= HALF_PI_Q16)
      else $error("deviation beyond pi/2");

   // Input is held off only when the whole pipeline is full and the result waits.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled while the pipeline has room");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

### verif/plane_normal_angle_deviation_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_normal_angle_deviation_unit_tb
// Self-checking bench for the plane normal angle deviation pipeline. Items of
// four points are driven on the request stream; a predictor computes the
// fixed-point deviation and degenerate flag of each, and every response is
// compared in order against the queue of predicted results.
// ----------------------------------------------------------------------------
module plane_normal_angle_deviation_unit_tb;
   import pnad_pkg::*;

   localparam int CW        = 32;
   localparam int REQ_W     = ((12 * CW + 7) / 8) * 8;
   localparam int LATENCY   = 70;
   localparam int STALL_MAX = 20000;

   typedef struct packed {
      logic [DEV_WIDTH-1:0] deviation;
      logic                 degenerate;
   } dev_result_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_W-1:0]          req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tuser;

   dev_result_type expected_devs[$];
   int             mismatch_count;
   int             idle_cycles;
   int             send_idle_pct;
   int             recv_stall_pct;
   int             hold_off_cycles;
   bit             timed_out;

   plane_normal_angle_deviation_unit #(.COORD_WIDTH(CW)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Magnitude of a signed 128-bit word, scaled so that a word of bit length len
   // becomes MANT_BITS bits long, then signed again.
   function automatic longint scale_component(input logic signed [127:0] v, input int len);
      logic [127:0] m;
      logic [127:0] r;
      m = v[127] ? -v : v;
      if (len > MANT_BITS) r = m >> (len - MANT_BITS);
      else r = m << (MANT_BITS - len);
      return v[127] ? -longint'(r[63:0]) : longint'(r[63:0]);
   endfunction

   function automatic int vec_bitlen(input logic signed [127:0] v[3]);
      logic [127:0] m;
      int len;
      len = 0;
      for (int i = 0; i < 3; i++) begin
         m = v[i][127] ? -v[i] : v[i];
         for (int b = 0; b < 128; b++) if (m[b] && b + 1 > len) len = b + 1;
      end
      return len;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned q);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > q) bitv >>= 2;
      while (bitv != 0) begin
         if (q >= res + bitv) begin
            q -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint shift_toward_zero(input longint v, input int s);
      longint unsigned m;
      m = v < 0 ? -v : v;
      m >>= s;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic dev_result_type predict_deviation(input logic [REQ_W-1:0] data);
      longint               pt[12];
      longint               d1[3], d2[3];
      logic signed [127:0]  nrm[3], tgt[3];
      longint               n[3], v[3], w[3];
      longint               dot, x, y, z, dx, dy;
      longint unsigned      md, mw[3], mx, q, c, dev;
      int                   len_n, len_t, s;
      dev_result_type       r;
      for (int i = 0; i < 12; i++) pt[i] = longint'(signed'(data[i*CW +: CW]));
      for (int i = 0; i < 3; i++) begin
         d1[i] = pt[3 + i] - pt[i];
         d2[i] = pt[6 + i] - pt[i];
         tgt[i] = 128'(signed'(pt[9 + i] - pt[i]));
      end
      nrm[0] = 128'(signed'(d1[1])) * d2[2] - 128'(signed'(d1[2])) * d2[1];
      nrm[1] = 128'(signed'(d1[2])) * d2[0] - 128'(signed'(d1[0])) * d2[2];
      nrm[2] = 128'(signed'(d1[0])) * d2[1] - 128'(signed'(d1[1])) * d2[0];
      len_n = vec_bitlen(nrm);
      len_t = vec_bitlen(tgt);
      if (len_n == 0 || len_t == 0) begin
         r.deviation = HALF_PI_Q16;
         r.degenerate = 1'b1;
         return r;
      end
      for (int i = 0; i < 3; i++) begin
         n[i] = scale_component(nrm[i], len_n);
         v[i] = scale_component(tgt[i], len_t);
      end
      dot = n[0] * v[0] + n[1] * v[1] + n[2] * v[2];
      w[0] = n[1] * v[2] - n[2] * v[1];
      w[1] = n[2] * v[0] - n[0] * v[2];
      w[2] = n[0] * v[1] - n[1] * v[0];
      md = dot < 0 ? -dot : dot;
      mx = md;
      for (int i = 0; i < 3; i++) begin
         mw[i] = w[i] < 0 ? -w[i] : w[i];
         if (mw[i] > mx) mx = mw[i];
      end
      s = 0;
      while ((mx >> s) >= (64'd1 << PAIR_BITS)) s++;
      q = 0;
      for (int i = 0; i < 3; i++) begin
         c = mw[i] >> s;
         q += c * c;
      end
      y = longint'(md >> s);
      x = longint'(int_sqrt(q));
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = shift_toward_zero(y, i);
         dy = shift_toward_zero(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
         end else begin
            x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
         end
      end
      dev = 0;
      if (z > 0) dev = (unsigned'(z) + 8192) >> 14;
      if (dev > HALF_PI_Q16) dev = HALF_PI_Q16;
      r.deviation = dev[DEV_WIDTH-1:0];
      r.degenerate = 1'b0;
      return r;
   endfunction

   // Sends one item: waits out a random sender gap, then holds it until taken.
   // The valid line stays high after the item is taken; a sender gap before the
   // next item or the next drain takes it down.
   task automatic send_points(input logic [CW-1:0] pts[12]);
      logic [REQ_W-1:0] data;
      data = '0;
      for (int i = 0; i < 12; i++) data[i*CW +: CW] = pts[i];
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      expected_devs = {expected_devs, predict_deviation(data)};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [CW-1:0] rand_coord(input int mode);
      case (mode)
         0: return $urandom;
         1: return CW'(signed'($urandom_range(2000)) - 1000);
         2: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3) :
                                       32'h8000_0000 + $urandom_range(3);
         default: return CW'(signed'($urandom_range(20_000_000)) - 10_000_000);
      endcase
   endfunction

   task automatic send_random(input int count);
      logic [CW-1:0] pts[12];
      int            mode, kind;
      for (int k = 0; k < count; k++) begin
         mode = $urandom_range(9) < 5 ? 3 : $urandom_range(2);
         for (int i = 0; i < 12; i++) pts[i] = rand_coord(mode);
         kind = $urandom_range(19);
         // Occasionally force collinear neighbors, a target on the center,
         // or a target lying in the plane.
         if (kind == 0) for (int i = 0; i < 3; i++) pts[6 + i] = pts[3 + i];
         if (kind == 1) for (int i = 0; i < 3; i++) pts[9 + i] = pts[i];
         if (kind == 2) for (int i = 0; i < 3; i++) pts[9 + i] = pts[3 + i];
         send_points(pts);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_devs.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      logic [CW-1:0] p[12];
      // Unit triangle in the xy plane; targets on the normal and in the plane.
      p = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
      send_points(p);
      p[9] = 32'h10000; p[11] = 0;
      send_points(p);
      p[9] = 32'h10000; p[10] = 32'h10000; p[11] = 32'h10000;
      send_points(p);
      p[11] = 32'hFFFF_0000;
      send_points(p);
      // Target equal to the center.
      p[9] = 0; p[10] = 0; p[11] = 0;
      send_points(p);
      // Collinear and coincident neighbors.
      p = '{0, 0, 0, 32'h10000, 0, 0, 32'h20000, 0, 0, 5, 7, 9};
      send_points(p);
      p = '{3, 3, 3, 3, 3, 3, 3, 3, 3, 9, 9, 9};
      send_points(p);
      // Extreme coordinates in every position.
      for (int e = 0; e < 4; e++) begin
         for (int i = 0; i < 12; i++)
            p[i] = ((i + e) % 3 == 0) ? 32'h8000_0000 :
                   ((i + e) % 3 == 1) ? 32'h7FFF_FFFF : 32'h0;
         send_points(p);
      end
      p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF};
      send_points(p);
      p = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 1, 2, 3, 32'hAAAA_AAAA,
            32'h5555_5555, 32'hFFFF_FFFF};
      send_points(p);
      // Tiny vectors of one LSB.
      p = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 1, 0};
      send_points(p);
      wait_drained();
   endtask

   task automatic test_random_phases();
      send_idle_pct = 0;  recv_stall_pct = 0;  send_random(350); wait_drained();
      send_idle_pct = 66; recv_stall_pct = 0;  send_random(300); wait_drained();
      send_idle_pct = 0;  recv_stall_pct = 66; send_random(300); wait_drained();
      send_idle_pct = 7;  recv_stall_pct = 7;  send_random(300); wait_drained();
   endtask

   // The receiver holds off long enough that the pipeline fills and stalls.
   task automatic test_back_pressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles <= 400;
      send_random(150);
      wait_drained();
   endtask

   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Checks each accepted response against the oldest prediction.
   always @(posedge clock) begin
      dev_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_devs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result: deviation %0d degenerate %0b",
                        rsp_tdata[DEV_WIDTH-1:0], rsp_tuser);
         end else begin
            want = expected_devs.pop_front();
            if (rsp_tdata[DEV_WIDTH-1:0] !== want.deviation || rsp_tuser !== want.degenerate) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: deviation exp %0d got %0d, degenerate exp %0b got %0b",
                           want.deviation, rsp_tdata[DEV_WIDTH-1:0], want.degenerate,
                           rsp_tuser);
            end
         end
      end
   end

   // Watchdog on cycles with no item moving on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_MAX && !timed_out) begin
            timed_out = 1'b1;
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      reset          <= 1'b1;
      req_tvalid     <= 1'b0;
      req_tdata      <= '0;
      mismatch_count = 0;
      idle_cycles    <= 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_cycles <= 0;
      timed_out      = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phases();
      test_back_pressure();
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0 && expected_devs.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### sim.f
rtl/pnad_pkg.sv
rtl/pnad_cross.sv
rtl/pnad_norm.sv
rtl/pnad_dot.sv
rtl/pnad_sqrt.sv
rtl/pnad_cordic.sv
rtl/plane_normal_angle_deviation_unit.sv
verif/plane_normal_angle_deviation_unit_tb.sv
